### rtl/ppc_pkg.sv
// Shared types and constants for the premultiplied pixel converter.
// No dependencies; imported by premultiplied_pixel_converter_core.
package ppc_pkg;

  localparam int DATA_W  = 64;
  localparam int CH_W    = 8;
  localparam int ACC_W   = 16;
  localparam int NUM_CH  = 3;
  localparam int NUM_STG = 4;

  localparam logic [CH_W-1:0]  FULL_ALPHA = 8'hFF;
  localparam logic [ACC_W-1:0] ROUND_BIAS = 16'd254;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CH_W-1:0]  quo;
    logic [CH_W-1:0]  col;
    logic             sat;
  } lane_t;

  typedef struct packed {
    logic                     mode;
    logic [CH_W-1:0]          alpha;
    logic                     scale;
    lane_t [NUM_CH-1:0]       lane;
  } stage_t;

endpackage

### rtl/premultiplied_pixel_converter_core.sv
// Premultiplied ARGB32<->RGBA byte converter, pipelined, a word/cycle unless stalled.
// Depends on ppc_pkg for stage types and constants.
//
// channel  dir  ports                      tdata / tuser
// in       in   in_tvalid/tready/tdata     surface_word, red, green, blue, alpha
//                   /tuser                  tuser: mode
// out      out  out_tvalid/tready/tdata    word_out, red, green, blue, alpha
// cfg      in   cfg_wen/cfg_wdata          byte_side_straight
//
// One word per cycle unless the output stalls; unpremultiply uses a radix-4
// restoring divider (two quotient bits per stage).
// Write mode scales with an 8x8 multiply and a divide-by-255 fold.
// Reset is synchronous, active low; byte_side_straight resets to 1.
// The whole pipeline holds when the output word is valid and not taken.
module premultiplied_pixel_converter_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ppc_pkg::DATA_W-1:0] in_tdata,  // surface_word, red, green, blue, alpha
  input  logic                      in_tuser,   // mode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ppc_pkg::DATA_W-1:0] out_tdata, // word_out, red, green, blue, alpha
  input  logic                      cfg_wen,
  input  logic                      cfg_wdata   // byte_side_straight
);
  import ppc_pkg::*;

  logic                  straight_r;
  logic                  vld_r   [1:NUM_STG];
  stage_t                s_r     [1:NUM_STG];
  stage_t                s_nxt   [1:NUM_STG];
  logic                  out_vld_r;
  logic [DATA_W-1:0]     out_data_r;
  logic [DATA_W-1:0]     out_data_nxt;
  logic                  adv;

  function automatic lane_t div_step(lane_t l, logic [CH_W-1:0] a, logic [2:0] sh);
    logic [ACC_W-1:0] d;
    lane_t            o;
    o = l;
    d = {{(ACC_W-CH_W){1'b0}}, a} << sh;
    if (o.acc >= d) begin
      o.acc     = o.acc - d;
      o.quo[sh] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [CH_W-1:0] div255(logic [ACC_W-1:0] x);
    logic [ACC_W:0] t;
    t = {1'b0, x} + {{ACC_W{1'b0}}, 1'b1} + {1'b0, (x >> CH_W)};
    return t[ACC_W-1:CH_W];
  endfunction

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [CH_W-1:0] c [NUM_CH];
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] ch [NUM_CH];
    stage_t          fin;

    // stage 1: unpack and form dividend or product
    s_nxt[1].mode = in_tuser;
    if (in_tuser == MODE_READ) begin
      a    = in_tdata[31:24];
      c[2] = in_tdata[23:16];
      c[1] = in_tdata[15:8];
      c[0] = in_tdata[7:0];
      s_nxt[1].scale = straight_r && (a != '0) && (a != FULL_ALPHA);
    end else begin
      a    = in_tdata[63:56];
      c[2] = in_tdata[39:32];
      c[1] = in_tdata[47:40];
      c[0] = in_tdata[55:48];
      s_nxt[1].scale = straight_r && (a != FULL_ALPHA);
    end
    s_nxt[1].alpha = a;
    for (int i = 0; i < NUM_CH; i++) begin
      s_nxt[1].lane[i].col = c[i];
      s_nxt[1].lane[i].quo = '0;
      s_nxt[1].lane[i].sat = (c[i] >= a);
      if (in_tuser == MODE_READ) begin
        s_nxt[1].lane[i].acc = {c[i], {CH_W{1'b0}}} - {{(ACC_W-CH_W){1'b0}}, c[i]};
      end else begin
        s_nxt[1].lane[i].acc = ({{(ACC_W-CH_W){1'b0}}, c[i]} *
                                {{(ACC_W-CH_W){1'b0}}, a}) + ROUND_BIAS;
      end
    end

    // stages 2..N: two read quotient bits per stage, write quotient in stage 2
    for (int k = 2; k <= NUM_STG; k++) begin
      s_nxt[k] = s_r[k-1];
      for (int i = 0; i < NUM_CH; i++) begin
        if (s_r[k-1].mode == MODE_READ) begin
          s_nxt[k].lane[i] = div_step(
            div_step(s_r[k-1].lane[i], s_r[k-1].alpha, 3'(2*(NUM_STG-k)+3)),
            s_r[k-1].alpha, 3'(2*(NUM_STG-k)+2));
        end else if (k == 2) begin
          s_nxt[k].lane[i].quo = div255(s_r[k-1].lane[i].acc);
        end
      end
    end

    // output stage: last two quotient bits, saturate and pack
    fin = s_r[NUM_STG];
    for (int i = 0; i < NUM_CH; i++) begin
      if (fin.mode == MODE_READ) begin
        fin.lane[i] = div_step(div_step(fin.lane[i], fin.alpha, 3'd1), fin.alpha, 3'd0);
      end
      if (!fin.scale) begin
        ch[i] = fin.lane[i].col;
      end else if (fin.mode == MODE_READ && fin.lane[i].sat) begin
        ch[i] = FULL_ALPHA;
      end else begin
        ch[i] = fin.lane[i].quo;
      end
    end
    if (fin.mode == MODE_READ) begin
      out_data_nxt = {fin.alpha, ch[0], ch[1], ch[2], 32'd0};
    end else begin
      out_data_nxt = {32'd0, fin.alpha, ch[2], ch[1], ch[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_r <= 1'b1;
      out_vld_r  <= 1'b0;
      for (int k = 1; k <= NUM_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_wen) begin
        straight_r <= cfg_wdata;
      end
      if (adv) begin
        vld_r[1]  <= in_tvalid;
        for (int k = 2; k <= NUM_STG; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
        out_vld_r <= vld_r[NUM_STG];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= NUM_STG; k++) begin
        s_r[k] <= s_nxt[k];
      end
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] != 32'd0) |-> (out_tdata[63:32] == 32'd0))
    else $error("read and write fields both nonzero");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STG] && s_r[NUM_STG].mode == MODE_READ && s_r[NUM_STG].scale &&
    !s_r[NUM_STG].lane[0].sat |->
    (s_r[NUM_STG].lane[0].acc < ({{(ACC_W-CH_W){1'b0}}, s_r[NUM_STG].alpha} << 2)))
    else $error("divider remainder out of range");

  a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld_r[1] == $past(vld_r[1])) && (vld_r[NUM_STG] == $past(vld_r[NUM_STG])))
    else $error("pipeline valid changed during stall");
`endif

endmodule
